>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg - shared types and constants for the sorted table key search
// Holds the command codes, the packed item and result types and the fixed
// field widths used by the top level.
// ----------------------------------------------------------------------------
package sts_pkg;

    // fixed field widths of the command and result ports
    localparam int CNT_W       = 9;
    localparam int IDX_FIELD_W = 8;
    localparam int KEY_FIELD_W = 32;

    // tables up to this many entries are scanned from index 0
    localparam logic [CNT_W-1:0] LINEAR_LIMIT = 9'd10;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                   cmd;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [KEY_FIELD_W-1:0] entry_key;
        logic [KEY_FIELD_W-1:0] search_key;
    } item_t;

    typedef struct packed
    {
        logic                   found;
        logic [IDX_FIELD_W-1:0] match_index;
    } result_t;

endpackage

>>> src/sorted_table_key_search.sv
// ----------------------------------------------------------------------------
// sorted_table_key_search - search of a sorted key table
// Loads keys entry by entry and looks up a key by a short linear scan or a
// binary search, one table probe per cycle.
// ----------------------------------------------------------------------------
//
//  channel   ports                          transfer
//  --------  -----------------------------  ----------------------------------
//  command   start, busy, item              start high and busy low at an edge
//  result    done, result                   done high for one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
//  A write command gives no result. A search makes up to n table probes
//  for a count n of at most ten, otherwise about log2(n) + 1 probes. The
//  key store has a single read port, so the search probes one entry at a
//  time. The result strobe rises as busy falls, so a new command may follow
//  at once. A count of zero answers in the next cycle.
//  Reset clears the sequencer and the entry count; the table stays undefined
//  until written. The receiver cannot hold a result off.
//
module sorted_table_key_search
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned KEY_BITS    = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sts_pkg::item_t               item,
    output logic                         done,
    output sts_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sts_pkg::CNT_W-1:0]    cfg_data
);

    // table address width, and a width that holds both the address and a count
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned AW    = (IDX_W > sts_pkg::CNT_W) ? IDX_W : sts_pkg::CNT_W;
    // stored key width: keys are masked to KEY_BITS, the port carries 32 bits
    localparam int unsigned KW    = (KEY_BITS < sts_pkg::KEY_FIELD_W) ?
                                    KEY_BITS : sts_pkg::KEY_FIELD_W;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LIN,
        ST_BIN,
        ST_FINAL
    } state_t;

    state_t                      state_reg,  state_next;
    logic                        done_reg,   done_next;
    sts_pkg::result_t            result_reg, result_next;
    logic [sts_pkg::CNT_W-1:0]   count_reg;

    // probe index (scan position, binary midpoint or last remaining entry)
    logic [sts_pkg::CNT_W-1:0]   idx_reg,    idx_next;
    logic [sts_pkg::CNT_W-1:0]   lo_reg,     lo_next;
    logic [sts_pkg::CNT_W-1:0]   hi_reg,     hi_next;
    logic [sts_pkg::CNT_W-1:0]   n_reg,      n_next;
    logic [KW-1:0]               key_reg,    key_next;

    logic [sts_pkg::CNT_W-1:0]   n_sat;
    logic [sts_pkg::CNT_W-1:0]   n_last;
    logic [sts_pkg::CNT_W-1:0]   lo_b;
    logic [sts_pkg::CNT_W-1:0]   hi_b;
    logic [sts_pkg::CNT_W:0]     mid_sum;
    logic [KW-1:0]               probe_key;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr_wide;
    logic [AW-1:0]               rd_addr_wide;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // counts above the table depth saturate
    always_comb
    begin
        if (32'(count_reg) > TABLE_DEPTH)
        begin
            n_sat = sts_pkg::CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = count_reg;
        end
    end

    assign n_last = n_sat - sts_pkg::CNT_W'(1);

    // write command: drop writes beyond the table
    assign wr_addr_wide = AW'(item.entry_index);
    assign wr_en        = start && !busy && (item.cmd == sts_pkg::CMD_WRITE) &&
                          (32'(item.entry_index) < TABLE_DEPTH);

    // the key store reads the next probe, so its data matches idx_reg
    assign rd_addr_wide = AW'(idx_next);

    sts_key_ram
    #(
        .DEPTH   (TABLE_DEPTH),
        .AW      (IDX_W),
        .KW      (KW)
    )
    u_key_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_wide[IDX_W-1:0]),
        .wr_data (item.entry_key[KW-1:0]),
        .rd_addr (rd_addr_wide[IDX_W-1:0]),
        .rd_data (probe_key)
    );

    // sequencer: one compare per cycle against the probed entry
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        n_next      = n_reg;
        key_next    = key_reg;
        lo_b        = lo_reg;
        hi_b        = hi_reg;
        mid_sum     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (item.cmd == sts_pkg::CMD_SEARCH))
                begin
                    key_next = item.search_key[KW-1:0];
                    n_next   = n_sat;
                    if (n_sat == '0)
                    begin
                        // empty table: answer not found at once
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else if (n_sat <= sts_pkg::LINEAR_LIMIT)
                    begin
                        idx_next   = '0;
                        state_next = ST_LIN;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = n_last;
                        idx_next   = n_last >> 1;
                        state_next = ST_BIN;
                    end
                end
            end

            ST_LIN:
            begin
                priority if (probe_key > key_reg)
                begin
                    // passed the place the key would sit
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else if (probe_key == key_reg)
                begin
                    done_next               = 1'b1;
                    result_next.found       = 1'b1;
                    result_next.match_index = idx_reg[sts_pkg::IDX_FIELD_W-1:0];
                    state_next              = ST_IDLE;
                end
                else if (idx_reg + sts_pkg::CNT_W'(1) == n_reg)
                begin
                    // scan exhausted
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + sts_pkg::CNT_W'(1);
                end
            end

            ST_BIN:
            begin
                if (probe_key == key_reg)
                begin
                    done_next               = 1'b1;
                    result_next.found       = 1'b1;
                    result_next.match_index = idx_reg[sts_pkg::IDX_FIELD_W-1:0];
                    state_next              = ST_IDLE;
                end
                else
                begin
                    if (key_reg < probe_key)
                    begin
                        hi_b = idx_reg;
                    end
                    else
                    begin
                        lo_b = idx_reg + sts_pkg::CNT_W'(1);
                    end
                    lo_next = lo_b;
                    hi_next = hi_b;
                    mid_sum = {1'b0, lo_b} + {1'b0, hi_b};
                    if (lo_b < hi_b)
                    begin
                        idx_next = mid_sum[sts_pkg::CNT_W:1];
                    end
                    else
                    begin
                        // one entry left: check it
                        idx_next   = lo_b;
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (probe_key == key_reg)
                begin
                    result_next.found       = 1'b1;
                    result_next.match_index = idx_reg[sts_pkg::IDX_FIELD_W-1:0];
                end
                else
                begin
                    result_next = '0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state, registered outputs and the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // search working registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        n_reg   <= n_next;
        key_reg <= key_next;
    end

endmodule

>>> src/sts_key_ram.sv
// ----------------------------------------------------------------------------
// sts_key_ram - key store of the sorted table key search
// Single write port and single read port; read data is registered, so a
// key appears in the cycle after its address.
// ----------------------------------------------------------------------------
module sts_key_ram
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned KW    = 32
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [KW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [KW-1:0] rd_data
);

    logic [KW-1:0] mem [DEPTH];
    logic [KW-1:0] rd_data_reg;

    // write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
